FILE: rtl/frml_pkg.sv
// Package for the frame rate meter and limiter.
// Holds the transaction payload structs and the fixed constants.
// No dependencies.
`default_nettype none

package frml_pkg;

	typedef struct packed {
		logic [31:0] frame_start_ticks;
		logic [31:0] now_ticks;
	} frame_t;

	typedef struct packed {
		logic [21:0] fps_q8;
		logic [15:0] frame_time_ms;
		logic [9:0]  delay_ms;
	} stat_t;

	localparam int unsigned FPS_W       = 22;
	localparam int unsigned GAP_W       = 16;
	localparam int unsigned LIMIT_W     = 10;
	localparam int unsigned FPS_SCALE   = 256000;  // 1000 fps with 8 fraction bits
	localparam int unsigned PERIOD_BASE = 1000;    // ms in one second
	localparam int unsigned PERIOD_BITS = 10;      // quotient bits of 1000/limit
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd60;
	localparam logic [FPS_W-1:0]   FPS_DEFAULT = 22'd15360;
	localparam logic [FPS_W-1:0]   FPS_MAX     = 22'h3FFFFF;

endpackage

`default_nettype wire

FILE: rtl/frml_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Dividend is left aligned; the caller picks the number of iterations.
// Depends on nothing but its parameters.
`default_nettype none

module frml_div #(
	parameter int unsigned NUM_W = 22,
	parameter int unsigned DEN_W = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [NUM_W-1:0]               dividend,
	input  wire logic [DEN_W-1:0]               divisor,
	input  wire logic [$clog2(NUM_W+1)-1:0]     n_iter,
	output logic                                busy,
	output logic                                done,
	output logic [NUM_W-1:0]                    quotient
);

	localparam int unsigned ITER_W = $clog2(NUM_W + 1);

	logic [ITER_W-1:0] cnt_q;
	logic              done_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  dvd_q;
	logic [NUM_W-1:0]  quo_q;

	logic [DEN_W:0]    trial;
	logic              fits;
	logic [DEN_W:0]    diff;

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= n_iter;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == ITER_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - ITER_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so DEN_W bits hold it
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/frml_ring.sv
// Gap history ring: one write port, one registered read port.
// Entries are undefined until written. No package dependency.
`default_nettype none

module frml_ring #(
	parameter int unsigned DEPTH  = 10,
	parameter int unsigned ADDR_W = 4,
	parameter int unsigned DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0]      rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/frame_rate_meter_limiter_top.sv
// Frame rate meter and limiter, top level with the sequencer.
// Sequence per frame: SUB and ADD update the gap sum, DIVP divides for the period (10 divider
// steps), DIVF for the average rate (NUM_W = 22 steps with the default window), DLY forms the
// delay and DONE presents the result; DIVF is skipped when the gap sum is zero.
// A new frame is taken only once the last result is emitted, as the single divider is shared.
// Reset: async active low; clears counters, sum and flags, limit goes to 60.
`default_nettype none

module frame_rate_meter_limiter_top #(
	parameter int unsigned WINDOW_LEN = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [frml_pkg::LIMIT_W-1:0]      cfg_data,
	input  wire logic                              frame_valid,
	output logic                                   frame_ready,
	input  wire frml_pkg::frame_t                  frame_data,
	output logic                                   stat_valid,
	input  wire logic                              stat_ready,
	output frml_pkg::stat_t                        stat_data
);

	localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned SUM_W  = frml_pkg::GAP_W + CNT_W;
	localparam int unsigned NUM_W  = 18 + CNT_W;
	localparam int unsigned ITER_W = $clog2(NUM_W + 1);
	localparam int unsigned QX_W   = (NUM_W > frml_pkg::FPS_W) ? NUM_W : frml_pkg::FPS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUB  = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_DIVP = 3'd3;
	localparam logic [2:0] S_DIVF = 3'd4;
	localparam logic [2:0] S_DLY  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]                       state_q;
	logic [frml_pkg::LIMIT_W-1:0]     limit_q;
	logic [SLOT_W-1:0]                slot_q;
	logic [CNT_W-1:0]                 fill_q;
	logic [SUM_W-1:0]                 sum_q;
	logic [31:0]                      last_end_q;
	logic                             seen_q;
	logic [frml_pkg::GAP_W-1:0]       gap_q;
	logic [31:0]                      busy_q;
	logic [frml_pkg::PERIOD_BITS-1:0] period_q;
	logic [frml_pkg::FPS_W-1:0]       fps_q;
	logic [9:0]                       delay_q;
	logic                             stat_valid_q;
	frml_pkg::stat_t                  stat_q;

	logic                             accept;
	logic                             full;
	logic                             emit;
	logic [31:0]                      raw_gap;
	logic [frml_pkg::GAP_W-1:0]       new_gap;
	logic [frml_pkg::GAP_W-1:0]       old_gap;
	logic                             ring_we;

	logic                             div_start;
	logic [NUM_W-1:0]                 div_dividend;
	logic [SUM_W-1:0]                 div_divisor;
	logic [ITER_W-1:0]                div_iter;
	logic                             div_busy;
	logic                             div_done;
	logic [NUM_W-1:0]                 div_quo;
	logic [QX_W-1:0]                  quo_x;
	logic [frml_pkg::LIMIT_W-1:0]     limit_eff;

	assign frame_ready = (state_q == S_IDLE);
	assign accept      = frame_valid && frame_ready;
	assign full        = (fill_q == CNT_W'(WINDOW_LEN));
	assign emit        = (state_q == S_DONE) && (!stat_valid_q || stat_ready);

	assign raw_gap = frame_data.now_ticks - last_end_q;
	assign new_gap = !seen_q ? '0 :
		(|raw_gap[31:frml_pkg::GAP_W]) ? '1 : raw_gap[frml_pkg::GAP_W-1:0];

	assign ring_we = (state_q == S_SUB);

	frml_ring #(
		.DEPTH  (WINDOW_LEN),
		.ADDR_W (SLOT_W),
		.DATA_W (frml_pkg::GAP_W)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (slot_q),
		.wdata (gap_q),
		.raddr (slot_q),
		.rdata (old_gap)
	);

	// Limit of zero behaves as one.
	assign limit_eff = (limit_q == '0) ? frml_pkg::LIMIT_W'(1) : limit_q;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = NUM_W'(frml_pkg::PERIOD_BASE) << (NUM_W - frml_pkg::PERIOD_BITS);
		div_divisor  = SUM_W'(limit_eff);
		div_iter     = ITER_W'(frml_pkg::PERIOD_BITS);
		case (state_q)
			S_ADD: begin
				div_start = 1'b1;
			end
			S_DIVP: begin
				if (div_done && sum_q != '0) begin
					div_start    = 1'b1;
					div_dividend = NUM_W'(frml_pkg::FPS_SCALE) * NUM_W'(fill_q);
					div_divisor  = sum_q;
					div_iter     = ITER_W'(NUM_W);
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	frml_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.n_iter   (div_iter),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo_x = QX_W'(div_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= frml_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			last_end_q   <= '0;
			seen_q       <= 1'b0;
			stat_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				stat_valid_q <= 1'b1;
			end else if (stat_ready) begin
				stat_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_end_q <= frame_data.now_ticks;
						seen_q     <= 1'b1;
						state_q    <= S_SUB;
					end
				end
				S_SUB: begin
					// old entry leaves the window only once it is full
					if (full) begin
						sum_q <= sum_q - SUM_W'(old_gap);
					end else begin
						fill_q <= fill_q + CNT_W'(1);
					end
					slot_q  <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
					state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q   <= sum_q + SUM_W'(gap_q);
					state_q <= S_DIVP;
				end
				S_DIVP: begin
					if (div_done) begin
						state_q <= (sum_q == '0) ? S_DLY : S_DIVF;
					end
				end
				S_DIVF: begin
					if (div_done) begin
						state_q <= S_DLY;
					end
				end
				S_DLY: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gap_q  <= new_gap;
			busy_q <= frame_data.now_ticks - frame_data.frame_start_ticks;
		end
		if (state_q == S_DIVP && div_done) begin
			period_q <= div_quo[frml_pkg::PERIOD_BITS-1:0];
			if (sum_q == '0) begin
				fps_q <= frml_pkg::FPS_DEFAULT;
			end
		end
		if (state_q == S_DIVF && div_done) begin
			fps_q <= (quo_x > QX_W'(frml_pkg::FPS_MAX)) ?
				frml_pkg::FPS_MAX : quo_x[frml_pkg::FPS_W-1:0];
		end
		if (state_q == S_DLY) begin
			delay_q <= (32'(period_q) > busy_q) ? (period_q - busy_q[9:0]) : '0;
		end
		if (emit) begin
			stat_q.fps_q8        <= fps_q;
			stat_q.frame_time_ms <= gap_q;
			stat_q.delay_ms      <= delay_q;
		end
	end

	assign stat_valid = stat_valid_q;
	assign stat_data  = stat_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_LEN))
		else $error("fill count beyond window length");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_q) < WINDOW_LEN)
		else $error("ring slot out of range");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (stat_valid && state_q == S_IDLE))
		else $error("result not presented after sequence end");
`endif

endmodule

`default_nettype wire
